// ===== hw/rtl/dsq_pkg.sv =====
// Shared types and constants for the door sensor qualifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dsq_pkg;

   localparam int FILTER_DEPTH = 8;
   localparam int PTR_W        = $clog2(FILTER_DEPTH);
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int TICK_W       = 32;

   typedef enum logic [1:0] {
      ST_OPEN   = 2'd0,
      ST_CLOSED = 2'd1,
      ST_LOCKED = 2'd2,
      ST_FAULT  = 2'd3
   } door_class_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFRESH_PERIOD = 1'd0,
      CSR_DEBOUNCE_TICKS = 1'd1
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] REFRESH_PERIOD_RESET = 16'd600;
   localparam logic [CSR_DATA_W-1:0] DEBOUNCE_TICKS_RESET = 16'd50;

   // Button fields of one request, handed to the debounce unit.
   typedef struct packed {
      logic              sampled;
      logic              level;
      logic [TICK_W-1:0] now_ticks;
   } btn_sample_type;

   function automatic door_class_type classify(input logic closed, input logic locked);
      door_class_type cls;
      if (!closed) begin
         cls = ST_OPEN;
      end else if (locked) begin
         cls = ST_LOCKED;
      end else begin
         cls = ST_CLOSED;
      end
      return cls;
   endfunction

   // Power-up ring contents: open, closed, locked, fault, then open.
   function automatic door_class_type ring_reset_value(input int idx);
      door_class_type val;
      unique case (idx)
         0:       val = ST_OPEN;
         1:       val = ST_CLOSED;
         2:       val = ST_LOCKED;
         3:       val = ST_FAULT;
         default: val = ST_OPEN;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/dsq_req_if.sv =====
// Request channel of the door sensor qualifier: one poll pass per request.
// Depends on dsq_pkg for the tick width.
`timescale 1ns / 1ps

interface dsq_req_if;
   import dsq_pkg::*;

   logic              valid;
   logic              ready;
   logic              closed_level;
   logic              locked_level;
   logic              button_sampled;
   logic              button_level;
   logic [TICK_W-1:0] now_ticks;

   modport source (output valid, closed_level, locked_level, button_sampled,
                   button_level, now_ticks, input ready);
   modport sink   (input valid, closed_level, locked_level, button_sampled,
                   button_level, now_ticks, output ready);
endinterface

// ===== hw/rtl/dsq_rsp_if.sv =====
// Response channel of the door sensor qualifier: one response per request.
// Depends on dsq_pkg for the state type.
`timescale 1ns / 1ps

interface dsq_rsp_if;
   import dsq_pkg::*;

   logic           valid;
   logic           ready;
   door_class_type smoothed_state;
   logic           stable;
   logic           publish_update;
   logic           button_event;

   modport source (output valid, smoothed_state, stable, publish_update, button_event,
                   input ready);
   modport sink   (input valid, smoothed_state, stable, publish_update, button_event,
                   output ready);
endinterface

// ===== hw/rtl/dsq_csr_if.sv =====
// Register write channel of the door sensor qualifier.
// Depends on dsq_pkg for the index and data widths.
`timescale 1ns / 1ps

interface dsq_csr_if;
   import dsq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  addr;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== hw/rtl/dsq_button.sv =====
// Push button debounce: accepts a sampled rising edge once the debounce
// interval has passed since the last accepted press. Depends on dsq_pkg.
`timescale 1ns / 1ps

module dsq_button (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  dsq_pkg::btn_sample_type        sample,
   input  logic [dsq_pkg::CSR_DATA_W-1:0] debounce_ticks,
   output logic                           button_event
);
   import dsq_pkg::*;

   logic              held_ff;
   logic              held_in;
   logic [TICK_W-1:0] last_press_ff;
   logic [TICK_W-1:0] last_press_in;
   logic [TICK_W-1:0] elapsed;
   logic              level_change;

   // Elapsed time wraps with the timestamp.
   assign elapsed      = sample.now_ticks - last_press_ff;
   assign level_change = sample.sampled && (sample.level != held_ff);

   always_comb begin
      held_in       = held_ff;
      last_press_in = last_press_ff;
      button_event  = 1'b0;
      if (level_change) begin
         held_in = sample.level;
         if (sample.level && (elapsed >= {{(TICK_W-CSR_DATA_W){1'b0}}, debounce_ticks})) begin
            last_press_in = sample.now_ticks;
            button_event  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= 1'b0;
         last_press_ff <= '0;
      end else if (accept) begin
         held_ff       <= held_in;
         last_press_ff <= last_press_in;
      end
   end

   a_event_on_press: assert property (@(posedge clock) disable iff (reset)
      accept && button_event |=> held_ff && (last_press_ff == $past(sample.now_ticks)))
      else $error("button event without a recorded press");

   a_no_event_unsampled: assert property (@(posedge clock) disable iff (reset)
      !sample.sampled |-> !button_event)
      else $error("button event on a pass without a sampled level");

endmodule

// ===== hw/rtl/door_sensor_qualifier_top.sv =====
// Door sensor qualifier: each accepted request is registered straight into the response
// register, one request per cycle; a request is taken while the response
// register is empty or being drained in the same cycle.
// Synchronous active-high reset restores the power-up ring, clears the
// pointer, countdown and button state, and reloads both registers.
// Depends on dsq_pkg, the three channel interfaces and dsq_button.
`timescale 1ns / 1ps

module door_sensor_qualifier_top (
   input  logic   clock,
   input  logic   reset,
   dsq_req_if.sink   req_chan,
   dsq_rsp_if.source rsp_chan,
   dsq_csr_if.sink   csr_chan
);
   import dsq_pkg::*;

   logic [CSR_DATA_W-1:0] refresh_period_ff;
   logic [CSR_DATA_W-1:0] debounce_ticks_ff;

   door_class_type        ring_ff [FILTER_DEPTH];
   door_class_type        ring_in [FILTER_DEPTH];
   logic [PTR_W-1:0]      ptr_ff;
   logic [PTR_W-1:0]      ptr_in;
   door_class_type        published_ff;
   door_class_type        published_in;
   logic [CSR_DATA_W-1:0] countdown_ff;
   logic [CSR_DATA_W-1:0] countdown_in;

   logic                  rsp_valid_ff;
   door_class_type        rsp_state_ff;
   door_class_type        rsp_state_in;
   logic                  rsp_stable_ff;
   logic                  rsp_stable_in;
   logic                  rsp_publish_ff;
   logic                  rsp_publish_in;
   logic                  rsp_event_ff;

   logic                  accept;
   logic                  csr_write;
   logic                  force_publish;
   logic                  btn_event;
   door_class_type        fresh_class;
   btn_sample_type        btn_sample;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   assign btn_sample.sampled   = req_chan.button_sampled;
   assign btn_sample.level     = req_chan.button_level;
   assign btn_sample.now_ticks = req_chan.now_ticks;

   dsq_button u_button (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .sample         (btn_sample),
      .debounce_ticks (debounce_ticks_ff),
      .button_event   (btn_event)
   );

   // Register writes; an unused index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_period_ff <= REFRESH_PERIOD_RESET;
         debounce_ticks_ff <= DEBOUNCE_TICKS_RESET;
      end else if (csr_write) begin
         unique case (csr_chan.addr)
            CSR_REFRESH_PERIOD: refresh_period_ff <= csr_chan.wdata;
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_chan.wdata;
            default: ;
         endcase
      end
   end

   assign fresh_class = classify(req_chan.closed_level, req_chan.locked_level);

   // The ring is judged with the fresh class already written in.
   always_comb begin
      for (int i = 0; i < FILTER_DEPTH; i++) begin
         ring_in[i] = (ptr_ff == PTR_W'(i)) ? fresh_class : ring_ff[i];
      end
      rsp_stable_in = 1'b1;
      for (int i = 1; i < FILTER_DEPTH; i++) begin
         if (ring_in[i] != ring_in[0]) begin
            rsp_stable_in = 1'b0;
         end
      end
      rsp_state_in = rsp_stable_in ? ring_in[0] : ST_FAULT;
      ptr_in = (ptr_ff == PTR_W'(FILTER_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   end

   // A zero countdown means a forced publish is due and it holds there.
   always_comb begin
      force_publish  = (countdown_ff == '0);
      countdown_in   = force_publish ? countdown_ff : countdown_ff - 1'b1;
      published_in   = published_ff;
      rsp_publish_in = 1'b0;
      if (rsp_stable_in && ((rsp_state_in != published_ff) || force_publish)) begin
         published_in   = rsp_state_in;
         countdown_in   = refresh_period_ff;
         rsp_publish_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILTER_DEPTH; i++) begin
            ring_ff[i] <= ring_reset_value(i);
         end
         ptr_ff       <= '0;
         published_ff <= ST_FAULT;
         countdown_ff <= '0;
      end else if (accept) begin
         ring_ff      <= ring_in;
         ptr_ff       <= ptr_in;
         published_ff <= published_in;
         countdown_ff <= countdown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_state_ff   <= rsp_state_in;
         rsp_stable_ff  <= rsp_stable_in;
         rsp_publish_ff <= rsp_publish_in;
         rsp_event_ff   <= btn_event;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.smoothed_state = rsp_state_ff;
   assign rsp_chan.stable         = rsp_stable_ff;
   assign rsp_chan.publish_update = rsp_publish_ff;
   assign rsp_chan.button_event   = rsp_event_ff;

   a_unstable_is_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stable_ff |-> (rsp_state_ff == ST_FAULT))
      else $error("unstable response carries a state other than fault");

   a_publish_needs_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_publish_ff |-> rsp_stable_ff)
      else $error("publish flagged on an unstable reading");

   a_publish_records_state: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_publish_in |=> (published_ff == rsp_state_ff)
                                  && (countdown_ff == $past(refresh_period_ff)))
      else $error("publish did not record state and reload countdown");

   a_pointer_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(FILTER_DEPTH - 1))
      else $error("ring pointer beyond filter depth");

endmodule
